>>> design/lrk_pkg.sv
// shared constants for the lorenz rk4 step block
`timescale 1ns / 1ps
package lrk_pkg;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] IDX_SIGMA = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] IDX_RHO   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] IDX_BETA  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] IDX_STEP  = 2'd3;

    // width of the step size register
    localparam int STEP_BITS = 31;

    // number of derivative evaluations of one rk4 step
    localparam int NUM_EVALS = 4;

endpackage

>>> design/lrk_if.sv
// channel interfaces of the lorenz rk4 step block
`timescale 1ns / 1ps

// state vector channel
interface lrk_state_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] in_x;
    logic signed [W-1:0] in_y;
    logic signed [W-1:0] in_z;
    modport source (output valid, in_x, in_y, in_z, input ready);
    modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

// result channel
interface lrk_result_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_x;
    logic signed [W-1:0] out_y;
    logic signed [W-1:0] out_z;
    logic                overflow_flag;
    modport source (output valid, out_x, out_y, out_z, overflow_flag, input ready);
    modport sink (input valid, out_x, out_y, out_z, overflow_flag, output ready);
endinterface

// configuration write channel
interface lrk_cfg_if #(parameter int IW = 2, parameter int DW = 32);
    logic          valid;
    logic          ready;
    logic [IW-1:0] index;
    logic [DW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> design/lorenz_rk4_step.sv
// lorenz rk4 step: top level, fully pipelined
// Usage:
//   cur  - state vector channel (in_x, in_y, in_z), signed fixed point
//   nxt  - result channel (out_x, out_y, out_z, overflow_flag)
//   cfg  - register writes: 0 sigma, 1 rho, 2 beta, 3 step size; always ready,
//          write only while the pipeline is empty
// Throughput: one state vector per cycle while the output is not stalled.
// Each of the four derivative evaluations takes five register stages
// (difference, products, sums, step scaling, update), then two stages
// divide the weighted sum by six and add it to the start point:
// 22 register stages in all.
// The whole pipeline advances together when the output register is empty
// or its result is being taken; while the receiver stalls every stage
// holds and cur.ready is low.
// Reset clears all valid bits and loads the default coefficients
// (sigma 10, rho 28, beta 8/3, step 0.01).
// overflow_flag is set when any intermediate or final value saturated.
`timescale 1ns / 1ps
module lorenz_rk4_step
    import lrk_pkg::*;
#(
    parameter int FRAC_BITS = 24,
    parameter int WORD_BITS = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    lrk_state_if.sink       cur,
    lrk_result_if.source    nxt,
    lrk_cfg_if.sink         cfg
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int HW = (W > STEP_BITS) ? W : STEP_BITS;
    localparam int PW = 2 * W + 1;
    localparam int K  = W + 3;

    typedef logic signed [W-1:0] word_t;

    localparam word_t WMAX = {1'b0, {(W-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(W-1){1'b0}}};

    // reset values; sigma, rho and beta clamped to the word range
    localparam logic signed [71:0] WMAX_EXT = 72'(WMAX);
    localparam logic signed [71:0] SIG_RAW  = 72'(10) << F;
    localparam logic signed [71:0] RHO_RAW  = 72'(28) << F;
    localparam logic signed [71:0] BETA_RAW = ((72'(8) << F) + 72'(1)) / 72'(3);
    localparam logic [71:0] STEP_RAW = ((72'(1) << F) + 72'(50)) / 72'(100);
    localparam word_t SIGMA_RST = (SIG_RAW > WMAX_EXT) ? WMAX : word_t'(SIG_RAW);
    localparam word_t RHO_RST   = (RHO_RAW > WMAX_EXT) ? WMAX : word_t'(RHO_RAW);
    localparam word_t BETA_RST  = (BETA_RAW > WMAX_EXT) ? WMAX : word_t'(BETA_RAW);
    localparam logic [STEP_BITS-1:0] STEP_RST = STEP_BITS'(STEP_RAW);

    // reciprocal of six for the final division
    localparam logic [W+3:0] KPOW = (W+4)'(1) << K;
    localparam logic [W:0] RECIP6 = (W+1)'(KPOW / 6);

    // saturating add, result {flag, value}
    function automatic logic [W:0] sat_add(input word_t a, input word_t b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            return {1'b1, (s[W] ? WMIN : WMAX)};
        return {1'b0, s[W-1:0]};
    endfunction

    // saturating subtract, result {flag, value}
    function automatic logic [W:0] sat_sub(input word_t a, input word_t b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
            return {1'b1, (s[W] ? WMIN : WMAX)};
        return {1'b0, s[W-1:0]};
    endfunction

    // fixed point multiply, magnitude rounded half away from zero
    function automatic logic [W:0] sat_mul(input word_t a, input word_t b);
        logic          neg;
        logic [W-1:0]  ua;
        logic [W-1:0]  ub;
        logic [PW-1:0] p;
        logic [PW-1:0] r;
        logic [PW-1:0] lim;
        neg = a[W-1] ^ b[W-1];
        ua  = a[W-1] ? W'(-a) : W'(a);
        ub  = b[W-1] ? W'(-b) : W'(b);
        p   = PW'(ua) * PW'(ub);
        p   = p + (PW'(1) << (F - 1));
        r   = p >> F;
        lim = PW'(WMAX) + PW'(neg);
        if (r > lim)
            return {1'b1, (neg ? WMIN : WMAX)};
        return {1'b0, (neg ? W'(-r[W-1:0]) : r[W-1:0])};
    endfunction

    // floor halving
    function automatic word_t half(input word_t a);
        return a >>> 1;
    endfunction

    // configuration registers
    word_t                sigma_reg;
    word_t                rho_reg;
    word_t                beta_reg;
    logic [STEP_BITS-1:0] step_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SIGMA_RST;
            rho_reg   <= RHO_RST;
            beta_reg  <= BETA_RST;
            step_reg  <= STEP_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                IDX_SIGMA: sigma_reg <= word_t'(cfg.data[W-1:0]);
                IDX_RHO:   rho_reg   <= word_t'(cfg.data[W-1:0]);
                IDX_BETA:  beta_reg  <= word_t'(cfg.data[W-1:0]);
                IDX_STEP:  step_reg  <= cfg.data[STEP_BITS-1:0];
                default:   ;
            endcase
        end
    end

    // step size limited to the word range
    logic [HW-1:0] step_ext;
    word_t         h_word;
    assign step_ext = HW'(step_reg);
    assign h_word   = (step_ext > HW'(WMAX)) ? WMAX : word_t'(step_ext[W-1:0]);

    // global pipeline advance
    logic  en;
    logic  out_v_reg;
    assign en        = !out_v_reg || nxt.ready;
    assign cur.ready = en;

    // pipeline registers, one set per derivative evaluation
    word_t src_x0 [NUM_EVALS][3];
    word_t src_s  [NUM_EVALS][3];
    word_t src_acc[NUM_EVALS][3];
    logic  src_f  [NUM_EVALS];
    logic  src_v  [NUM_EVALS];

    word_t a_x0_reg [NUM_EVALS][3];
    word_t a_s_reg  [NUM_EVALS][3];
    word_t a_acc_reg[NUM_EVALS][3];
    word_t a_diff_reg[NUM_EVALS];
    logic  a_f_reg  [NUM_EVALS];
    logic  a_v_reg  [NUM_EVALS];

    word_t b_x0_reg [NUM_EVALS][3];
    word_t b_acc_reg[NUM_EVALS][3];
    word_t b_s1_reg [NUM_EVALS];
    word_t b_m_reg  [NUM_EVALS][5];
    logic  b_f_reg  [NUM_EVALS];
    logic  b_v_reg  [NUM_EVALS];

    word_t c_x0_reg [NUM_EVALS][3];
    word_t c_acc_reg[NUM_EVALS][3];
    word_t c_dv_reg [NUM_EVALS][3];
    logic  c_f_reg  [NUM_EVALS];
    logic  c_v_reg  [NUM_EVALS];

    word_t d_x0_reg [NUM_EVALS][3];
    word_t d_acc_reg[NUM_EVALS][3];
    word_t d_d_reg  [NUM_EVALS][3];
    logic  d_f_reg  [NUM_EVALS];
    logic  d_v_reg  [NUM_EVALS];

    word_t e_x0_reg [NUM_EVALS][3];
    word_t e_s_reg  [NUM_EVALS][3];
    word_t e_acc_reg[NUM_EVALS][3];
    logic  e_f_reg  [NUM_EVALS];
    logic  e_v_reg  [NUM_EVALS];

    for (genvar k = 0; k < NUM_EVALS; k++)
    begin : g_eval
        logic [W:0] diff_r;
        logic [W:0] m_r [5];
        logic [W:0] t_r;
        logic [W:0] dv1_r;
        logic [W:0] dv2_r;
        logic [W:0] dd_r [3];
        logic [W:0] xa_r [3];
        logic [W:0] acc_r [3];
        logic [2:0] dd_f;
        logic [2:0] xa_f;
        logic [2:0] acc_f;

        // stage input: the new vector or the previous evaluation
        if (k == 0)
        begin : g_src_in
            assign src_x0[k][0] = cur.in_x;
            assign src_x0[k][1] = cur.in_y;
            assign src_x0[k][2] = cur.in_z;
            assign src_s[k]     = src_x0[k];
            assign src_acc[k]   = '{default: '0};
            assign src_f[k]     = 1'b0;
            assign src_v[k]     = cur.valid;
        end
        else
        begin : g_src_prev
            assign src_x0[k]  = e_x0_reg[k-1];
            assign src_s[k]   = e_s_reg[k-1];
            assign src_acc[k] = e_acc_reg[k-1];
            assign src_f[k]   = e_f_reg[k-1];
            assign src_v[k]   = e_v_reg[k-1];
        end

        // difference y - x
        assign diff_r = sat_sub(src_s[k][1], src_s[k][0]);

        // the five products of the derivative
        assign m_r[0] = sat_mul(sigma_reg, a_diff_reg[k]);
        assign m_r[1] = sat_mul(rho_reg, a_s_reg[k][0]);
        assign m_r[2] = sat_mul(a_s_reg[k][0], a_s_reg[k][2]);
        assign m_r[3] = sat_mul(a_s_reg[k][0], a_s_reg[k][1]);
        assign m_r[4] = sat_mul(beta_reg, a_s_reg[k][2]);

        // derivative sums
        assign t_r   = sat_sub(b_m_reg[k][1], b_s1_reg[k]);
        assign dv1_r = sat_sub(word_t'(t_r[W-1:0]), b_m_reg[k][2]);
        assign dv2_r = sat_sub(b_m_reg[k][3], b_m_reg[k][4]);

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            // scale by the step
            assign dd_r[i] = sat_mul(h_word, c_dv_reg[k][i]);
            assign dd_f[i] = dd_r[i][W];

            // intermediate point
            if (k < 2)
            begin : g_xa_half
                assign xa_r[i] = sat_add(d_x0_reg[k][i], half(d_d_reg[k][i]));
            end
            else if (k == 2)
            begin : g_xa_full
                assign xa_r[i] = sat_add(d_x0_reg[k][i], d_d_reg[k][i]);
            end
            else
            begin : g_xa_none
                assign xa_r[i] = {1'b0, d_x0_reg[k][i]};
            end
            assign xa_f[i] = xa_r[i][W];

            // weighted sum d1 + 2*d2 + 2*d3 + d4
            if (k == 0)
            begin : g_acc_first
                assign acc_r[i] = {1'b0, d_d_reg[k][i]};
                assign acc_f[i] = 1'b0;
            end
            else if (k < 3)
            begin : g_acc_double
                logic [W:0] dbl_r;
                logic [W:0] sum_r;
                assign dbl_r    = sat_add(d_d_reg[k][i], d_d_reg[k][i]);
                assign sum_r    = sat_add(d_acc_reg[k][i], word_t'(dbl_r[W-1:0]));
                assign acc_r[i] = sum_r;
                assign acc_f[i] = sum_r[W] | dbl_r[W];
            end
            else
            begin : g_acc_last
                assign acc_r[i] = sat_add(d_acc_reg[k][i], d_d_reg[k][i]);
                assign acc_f[i] = acc_r[i][W];
            end
        end

        // payload stages
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_x0_reg[k]   <= src_x0[k];
                a_s_reg[k]    <= src_s[k];
                a_acc_reg[k]  <= src_acc[k];
                a_diff_reg[k] <= diff_r[W-1:0];
                a_f_reg[k]    <= src_f[k] | diff_r[W];

                b_x0_reg[k]  <= a_x0_reg[k];
                b_acc_reg[k] <= a_acc_reg[k];
                b_s1_reg[k]  <= a_s_reg[k][1];
                for (int j = 0; j < 5; j++)
                    b_m_reg[k][j] <= m_r[j][W-1:0];
                b_f_reg[k] <= a_f_reg[k] | m_r[0][W] | m_r[1][W] | m_r[2][W]
                              | m_r[3][W] | m_r[4][W];

                c_x0_reg[k]    <= b_x0_reg[k];
                c_acc_reg[k]   <= b_acc_reg[k];
                c_dv_reg[k][0] <= b_m_reg[k][0];
                c_dv_reg[k][1] <= dv1_r[W-1:0];
                c_dv_reg[k][2] <= dv2_r[W-1:0];
                c_f_reg[k]     <= b_f_reg[k] | t_r[W] | dv1_r[W] | dv2_r[W];

                d_x0_reg[k]  <= c_x0_reg[k];
                d_acc_reg[k] <= c_acc_reg[k];
                for (int j = 0; j < 3; j++)
                    d_d_reg[k][j] <= dd_r[j][W-1:0];
                d_f_reg[k] <= c_f_reg[k] | (|dd_f);

                e_x0_reg[k] <= d_x0_reg[k];
                for (int j = 0; j < 3; j++)
                begin
                    e_s_reg[k][j]   <= xa_r[j][W-1:0];
                    e_acc_reg[k][j] <= acc_r[j][W-1:0];
                end
                e_f_reg[k] <= d_f_reg[k] | (|xa_f) | (|acc_f);
            end
        end

        // valid bits
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_v_reg[k] <= 1'b0;
                b_v_reg[k] <= 1'b0;
                c_v_reg[k] <= 1'b0;
                d_v_reg[k] <= 1'b0;
                e_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                a_v_reg[k] <= src_v[k];
                b_v_reg[k] <= a_v_reg[k];
                c_v_reg[k] <= b_v_reg[k];
                d_v_reg[k] <= c_v_reg[k];
                e_v_reg[k] <= d_v_reg[k];
            end
        end
    end

    // division by six, first stage: magnitude times reciprocal
    word_t        f1_x0_reg [3];
    logic [W-1:0] f1_u_reg  [3];
    logic [W-1:0] f1_q0_reg [3];
    logic         f1_neg_reg[3];
    logic         f1_f_reg;
    logic         f1_v_reg;

    // division by six, second stage: correction, rounding and final add
    word_t        out_x_reg [3];
    logic         out_f_reg;
    logic [2:0]   fin_f;
    logic [W:0]   fin_r [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_final
        word_t         acc;
        logic [W-1:0]  u;
        logic [PW-1:0] prod;
        logic [W+3:0]  r0;
        logic [W+3:0]  r1;
        logic [W-1:0]  q1;
        logic [W-1:0]  q;
        word_t         s6;

        assign acc  = e_acc_reg[NUM_EVALS-1][i];
        assign u    = acc[W-1] ? W'(-acc) : W'(acc);
        assign prod = PW'(u) * PW'(RECIP6);

        assign r0 = (W+4)'(f1_u_reg[i]) - (W+4)'(f1_q0_reg[i]) * (W+4)'(6);
        assign q1 = (r0 >= (W+4)'(6)) ? f1_q0_reg[i] + W'(1) : f1_q0_reg[i];
        assign r1 = (r0 >= (W+4)'(6)) ? r0 - (W+4)'(6) : r0;
        assign q  = (r1 >= (W+4)'(3)) ? q1 + W'(1) : q1;
        assign s6 = f1_neg_reg[i] ? word_t'(-q) : word_t'(q);
        assign fin_r[i] = sat_add(f1_x0_reg[i], s6);
        assign fin_f[i] = fin_r[i][W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f1_x0_reg[i]  <= e_x0_reg[NUM_EVALS-1][i];
                f1_u_reg[i]   <= u;
                f1_q0_reg[i]  <= W'(prod >> K);
                f1_neg_reg[i] <= acc[W-1];
                out_x_reg[i]  <= fin_r[i][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_f_reg  <= e_f_reg[NUM_EVALS-1];
            out_f_reg <= f1_f_reg | (|fin_f);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg  <= e_v_reg[NUM_EVALS-1];
            out_v_reg <= f1_v_reg;
        end
    end

    // result channel
    assign nxt.valid         = out_v_reg;
    assign nxt.out_x         = out_x_reg[0];
    assign nxt.out_y         = out_x_reg[1];
    assign nxt.out_z         = out_x_reg[2];
    assign nxt.overflow_flag = out_f_reg;

    // a stalled pipeline keeps its first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(a_v_reg[0]))
        else $error("first stage valid changed during stall");

    // last evaluation moves into the divide stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && e_v_reg[NUM_EVALS-1]) |=> f1_v_reg)
        else $error("item lost between last evaluation and divide stage");

    // divide stage moves into the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && f1_v_reg) |=> out_v_reg)
        else $error("item lost before output register");

endmodule

>>> tb/tb_lorenz_rk4_step.sv
// testbench for the lorenz rk4 step block: directed and random state vectors checked against a local model
`timescale 1ns / 1ps
module tb_lorenz_rk4_step
    import lrk_pkg::*;
();

    localparam int FB = 24;
    localparam int WB = 32;
    localparam longint WMAXV = 64'sd2147483647;
    localparam longint WMINV = -64'sd2147483648;
    localparam int LATENCY = 22;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               ovf;
    } next_t;

    logic clk;
    logic rst_n;

    lrk_state_if #(WB)       cur ();
    lrk_result_if #(WB)      nxt ();
    lrk_cfg_if #(CFG_IDX_BITS, WB) cfg ();

    lorenz_rk4_step #(.FRAC_BITS(FB), .WORD_BITS(WB)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cur   (cur),
        .nxt   (nxt),
        .cfg   (cfg)
    );

    // local copy of the coefficients
    longint sigma_c, rho_c, beta_c, step_c;
    bit     sat_hit;

    next_t  expected_steps[$];
    int     mismatches;
    longint cycles;
    bit     hold_off;
    int     gap_max;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_lorenz_rk4_step failed");
            $finish;
        end
    end

    // saturating word arithmetic
    function automatic longint sat_word(longint v);
        if (v > WMAXV)
        begin
            sat_hit = 1'b1;
            return WMAXV;
        end
        if (v < WMINV)
        begin
            sat_hit = 1'b1;
            return WMINV;
        end
        return v;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        logic signed [127:0] p;
        logic [127:0] m;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = 128'(signed'(a)) * 128'(signed'(b));
        m = p < 0 ? -p : p;
        m = (m + (128'd1 << (FB - 1))) >> FB;
        if (!neg && m > 128'(WMAXV))
        begin
            sat_hit = 1'b1;
            return WMAXV;
        end
        if (neg && m > 128'(WMAXV) + 1)
        begin
            sat_hit = 1'b1;
            return WMINV;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint q_half(longint a);
        return a >>> 1;
    endfunction

    function automatic longint q_sixth(longint a);
        longint u, q;
        u = a < 0 ? -a : a;
        q = u / 6 + ((u % 6) >= 3 ? 1 : 0);
        return a < 0 ? -q : q;
    endfunction

    // lorenz vector field, scaled by h
    function automatic void lorenz_rate(input longint s[3], output longint d[3]);
        longint f[3];
        f[0] = q_mul(sigma_c, sat_word(s[1] - s[0]));
        f[1] = sat_word(sat_word(q_mul(rho_c, s[0]) - s[1]) - q_mul(s[0], s[2]));
        f[2] = sat_word(q_mul(s[0], s[1]) - q_mul(beta_c, s[2]));
        for (int i = 0; i < 3; i++)
            d[i] = q_mul(step_c, f[i]);
    endfunction

    // one rk4 step
    function automatic next_t rk4_next(vec_t v);
        longint x0[3], xa[3], d1[3], d2[3], d3[3], d4[3], s;
        next_t r;
        sat_hit = 1'b0;
        x0[0] = v.x;
        x0[1] = v.y;
        x0[2] = v.z;
        lorenz_rate(x0, d1);
        for (int i = 0; i < 3; i++)
            xa[i] = sat_word(x0[i] + q_half(d1[i]));
        lorenz_rate(xa, d2);
        for (int i = 0; i < 3; i++)
            xa[i] = sat_word(x0[i] + q_half(d2[i]));
        lorenz_rate(xa, d3);
        for (int i = 0; i < 3; i++)
            xa[i] = sat_word(x0[i] + d3[i]);
        lorenz_rate(xa, d4);
        for (int i = 0; i < 3; i++)
        begin
            s = sat_word(d1[i] + sat_word(d2[i] + d2[i]));
            s = sat_word(s + sat_word(d3[i] + d3[i]));
            s = sat_word(s + d4[i]);
            xa[i] = sat_word(x0[i] + q_sixth(s));
        end
        r.x = 32'(xa[0]);
        r.y = 32'(xa[1]);
        r.z = 32'(xa[2]);
        r.ovf = sat_hit;
        return r;
    endfunction

    // send one state vector; valid stays high after the transfer
    task automatic send_state(vec_t v);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            cur.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur.valid <= 1'b1;
        cur.in_x  <= v.x;
        cur.in_y  <= v.y;
        cur.in_z  <= v.z;
        @(posedge clk);
        while (!cur.ready) @(posedge clk);
        expected_steps.push_back(rk4_next(v));
        @(negedge clk);
    endtask

    // register write while the pipeline is empty
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        case (idx)
            IDX_SIGMA: sigma_c = longint'(signed'(val));
            IDX_RHO:   rho_c = longint'(signed'(val));
            IDX_BETA:  beta_c = longint'(signed'(val));
            IDX_STEP:  step_c = longint'(val[30:0]);
            default:   ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        cur.valid <= 1'b0;
        while (expected_steps.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h7FF) - 32'h400;
            3: return $urandom;
            default: return $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        endcase
    endfunction

    function automatic vec_t rand_state();
        vec_t v;
        if ($urandom_range(0, 3) == 0)
        begin
            v.x = rand_word();
            v.y = rand_word();
            v.z = rand_word();
        end
        else
        begin
            // points near the attractor, values below about 64
            v.x = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
            v.y = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
            v.z = $urandom_range(0, 32'h3FFF_FFFF) - 32'h0800_0000;
        end
        return v;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        next_t got, want;
        if (rst_n && nxt.valid && nxt.ready)
        begin
            got.x = nxt.out_x;
            got.y = nxt.out_y;
            got.z = nxt.out_z;
            got.ovf = nxt.overflow_flag;
            if (expected_steps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_steps.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h ovf=%b got x=%h y=%h z=%h ovf=%b",
                                 want.x, want.y, want.z, want.ovf,
                                 got.x, got.y, got.z, got.ovf);
                end
            end
        end
    end

    // receiver with random stalls and a long hold-off on request
    initial
    begin
        int wait_n;
        nxt.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                nxt.ready <= 1'b0;
            else if (gap_max == 0)
                nxt.ready <= 1'b1;
            else
            begin
                wait_n = $urandom_range(0, gap_max);
                if (wait_n > 0)
                begin
                    nxt.ready <= 1'b0;
                    repeat (wait_n) @(negedge clk);
                end
                nxt.ready <= 1'b1;
            end
        end
    end

    task automatic test_defaults();
        vec_t v;
        v = '{x: 32'h0100_0000, y: 32'h0100_0000, z: 32'h0100_0000};
        send_state(v);
        send_state('0);
        v = '{x: 32'h7FFF_FFFF, y: 32'h7FFF_FFFF, z: 32'h7FFF_FFFF};
        send_state(v);
        v = '{x: 32'h8000_0000, y: 32'h8000_0000, z: 32'h8000_0000};
        send_state(v);
        v = '{x: 32'h7FFF_FFFF, y: 32'h8000_0000, z: 32'h0000_0001};
        send_state(v);
        v = '{x: 32'hFFFF_FFFF, y: 32'h0000_0001, z: 32'hFFFF_FFFF};
        send_state(v);
        v = '{x: 32'h0A00_0000, y: 32'hF600_0000, z: 32'h1400_0000};
        send_state(v);
        drain();
    endtask

    task automatic test_extreme_config();
        write_reg(IDX_SIGMA, 32'h7FFF_FFFF);
        write_reg(IDX_RHO, 32'h8000_0000);
        write_reg(IDX_BETA, 32'h0000_0000);
        write_reg(IDX_STEP, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_state(rand_state());
        drain();
        write_reg(IDX_SIGMA, 32'h8000_0000);
        write_reg(IDX_RHO, 32'h7FFF_FFFF);
        write_reg(IDX_BETA, 32'hFFFF_FFFF);
        write_reg(IDX_STEP, 32'h0000_0000);
        for (int i = 0; i < 6; i++)
            send_state(rand_state());
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_state(rand_state());
        drain();
    endtask

    task automatic test_random_config();
        write_reg(IDX_SIGMA, $urandom);
        write_reg(IDX_RHO, $urandom_range(0, 32'h3FFF_FFFF) - 32'h1000_0000);
        write_reg(IDX_BETA, $urandom_range(0, 32'h0FFF_FFFF));
        write_reg(IDX_STEP, $urandom_range(0, 32'h00FF_FFFF));
        test_random(150);
    endtask

    // back pressure: receiver stops while the sender keeps offering
    task automatic test_backpressure();
        gap_max = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 60; i++)
                send_state(rand_state());
        join
        drain();
        gap_max = 14;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        mismatches = 0;
        hold_off = 1'b0;
        gap_max = 14;
        cur.valid = 1'b0;
        cur.in_x = '0;
        cur.in_y = '0;
        cur.in_z = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        sigma_c = 64'sd167772160;
        rho_c = 64'sd469762048;
        beta_c = 64'sd44739243;
        step_c = 64'sd167772;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_defaults();
        test_extreme_config();
        write_reg(IDX_SIGMA, 32'd167772160);
        write_reg(IDX_RHO, 32'd469762048);
        write_reg(IDX_BETA, 32'd44739243);
        write_reg(IDX_STEP, 32'd167772);
        test_random(300);
        test_backpressure();
        test_random_config();
        test_random_config();
        gap_max = 0;
        test_random(150);
        gap_max = 14;
        test_random(100);

        if (mismatches == 0 && expected_steps.size() == 0)
            $display("tb_lorenz_rk4_step passed");
        else
            $display("tb_lorenz_rk4_step failed");
        $finish;
    end

endmodule
